/* design/ale_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ale_pkg;

   // Operation codes carried in the func field
   localparam logic [2:0] FN_INSERT = 3'd0;
   localparam logic [2:0] FN_DELETE = 3'd1;
   localparam logic [2:0] FN_LOCATE = 3'd2;
   localparam logic [2:0] FN_SORTED = 3'd3;
   localparam logic [2:0] FN_CLEAR  = 3'd4;

   // Status codes returned with each response
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BADPOS   = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
      logic [4:0]         position;
   } ale_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] index;
      logic [4:0] count;
   } ale_rsp_type;

   // Per-cell control from the sequencer
   typedef struct packed {
      logic cmp_en;      // capture compare flags
      logic live;        // cell holds a list entry
      logic take_new;    // load the request value
      logic shift_up;    // load from lower neighbor
      logic shift_down;  // load from upper neighbor
   } ale_cell_ctrl_type;

   // Compare flags returned by each cell
   typedef struct packed {
      logic eq;    // live entry equals the key
      logic stop;  // sorted insert stops here
   } ale_cell_flags_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CMP  = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } ale_state_type;

endpackage

`default_nettype wire

/* design/ale_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ale_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/ale_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module ale_cell (
   input  wire logic                        clock,
   input  wire ale_pkg::ale_cell_ctrl_type  ctrl,
   input  wire logic signed [31:0]          key,
   input  wire logic signed [31:0]          lower,
   input  wire logic signed [31:0]          upper,
   output logic signed [31:0]               entry,
   output ale_pkg::ale_cell_flags_type      flags
);

   logic signed [31:0]          entry_ff;
   logic signed [31:0]          entry_in;
   ale_pkg::ale_cell_flags_type flags_ff;
   ale_pkg::ale_cell_flags_type flags_in;

   // Entry update: new value, shift from a neighbor, or hold
   always_comb begin
      if (ctrl.take_new) begin
         entry_in = key;
      end else if (ctrl.shift_up) begin
         entry_in = lower;
      end else if (ctrl.shift_down) begin
         entry_in = upper;
      end else begin
         entry_in = entry_ff;
      end
   end

   // Local compare against the request key
   always_comb begin
      flags_in.eq   = ctrl.live && (entry_ff == key);
      flags_in.stop = !(ctrl.live && (entry_ff < key));
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctrl.cmp_en) begin
         flags_ff <= flags_in;
      end
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

`default_nettype wire

/* design/array_list_engine.sv */
// Operation: the request is registered on acceptance, then the cells capture
// their compare flags, the first hit is scanned into the slot select, and the
// response valid is raised as the result is applied/shifted through the cell
// row. A new request is accepted only once the previous one has finished these
// steps; the last step waits while the response register is still held by the sink.
// Reset: clears the entry count, sequencer and response valid; the cell
// contents are not cleared and hold no meaning until written.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine #(
   parameter int CAPACITY = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ale_stream_if.sink   req_if,
   ale_stream_if.source rsp_if
);

   localparam int CNTW = $clog2(CAPACITY + 1);
   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW   = (CNTW > 5) ? CNTW : 5;
   localparam int IXW  = (IW > 4) ? IW : 4;

   ale_pkg::ale_state_type state_ff;
   ale_pkg::ale_state_type state_in;
   ale_pkg::ale_req_type   req_ff;
   logic [CNTW-1:0]        count_ff;
   logic [CNTW-1:0]        count_in;
   logic [CAPACITY-1:0]    sel_ff;
   logic [CAPACITY-1:0]    sel_in;
   logic                   rsp_valid_ff;
   ale_pkg::ale_rsp_type   rsp_data_ff;

   logic signed [31:0]          cell_data  [CAPACITY];
   ale_pkg::ale_cell_flags_type cell_flags [CAPACITY];
   ale_pkg::ale_cell_ctrl_type  cell_ctrl  [CAPACITY];

   logic [CAPACITY-1:0] live;
   logic [CAPACITY-1:0] eq_vec;
   logic [CAPACITY-1:0] stop_vec;
   logic [CAPACITY-1:0] pos_vec;
   logic [CAPACITY-1:0] scan_vec;
   logic [CAPACITY-1:0] ge_mask;
   logic [IW-1:0]       enc;
   logic [IXW-1:0]      idx_ext;
   logic [PW-1:0]       pos_ext;
   logic [PW-1:0]       cnt_ext;
   logic [PW-1:0]       cnt_out_ext;
   logic                is_full;
   logic                req_fire;
   logic                rsp_free;
   logic                done_go;
   logic                apply_ins;
   logic                apply_del;
   logic [1:0]          status_c;
   logic [3:0]          index_c;
   logic [CNTW-1:0]     count_next;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign done_go  = (state_ff == ale_pkg::S_DONE) && rsp_free;
   assign pos_ext  = PW'(req_ff.position);
   assign cnt_ext  = PW'(count_ff);
   assign is_full  = (count_ff == CNTW'(CAPACITY));

   // Per-cell vectors: occupancy, compare flags, decoded position
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         live[i]     = (count_ff > CNTW'(i));
         eq_vec[i]   = cell_flags[i].eq;
         stop_vec[i] = cell_flags[i].stop;
         pos_vec[i]  = (pos_ext == PW'(i));
      end
   end

   // Scan: isolate the lowest set bit of the selected vector
   always_comb begin
      unique case (req_ff.func)
         ale_pkg::FN_LOCATE: scan_vec = eq_vec;
         ale_pkg::FN_SORTED: scan_vec = stop_vec;
         default:            scan_vec = pos_vec;
      endcase
      sel_in = scan_vec & (~scan_vec + CAPACITY'(1));
   end

   // Slot index and the mask of cells at or above the slot
   always_comb begin
      enc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (sel_ff[i]) begin
            enc = enc | IW'(i);
         end
      end
      ge_mask = ~(sel_ff - CAPACITY'(1));
      idx_ext = IXW'(enc);
   end

   // Operation outcome
   always_comb begin
      status_c   = ale_pkg::ST_OK;
      index_c    = '0;
      count_next = count_ff;
      apply_ins  = 1'b0;
      apply_del  = 1'b0;
      unique case (req_ff.func)
         ale_pkg::FN_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status_c = ale_pkg::ST_BADPOS;
            end else if (is_full) begin
               status_c = ale_pkg::ST_FULL;
            end else begin
               apply_ins  = 1'b1;
               index_c    = idx_ext[3:0];
               count_next = count_ff + CNTW'(1);
            end
         end
         ale_pkg::FN_DELETE: begin
            if (pos_ext >= cnt_ext) begin
               status_c = ale_pkg::ST_BADPOS;
            end else begin
               apply_del  = 1'b1;
               count_next = count_ff - CNTW'(1);
            end
         end
         ale_pkg::FN_LOCATE: begin
            if (|sel_ff) begin
               index_c = idx_ext[3:0];
            end else begin
               status_c = ale_pkg::ST_NOTFOUND;
            end
         end
         ale_pkg::FN_SORTED: begin
            if (is_full) begin
               status_c = ale_pkg::ST_FULL;
            end else begin
               apply_ins  = 1'b1;
               index_c    = idx_ext[3:0];
               count_next = count_ff + CNTW'(1);
            end
         end
         ale_pkg::FN_CLEAR: begin
            count_next = '0;
         end
         default: begin
         end
      endcase
      cnt_out_ext = PW'(count_next);
   end

   // Cell controls
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ctrl[i].cmp_en     = (state_ff == ale_pkg::S_CMP);
         cell_ctrl[i].live       = live[i];
         cell_ctrl[i].take_new   = done_go && apply_ins && sel_ff[i];
         cell_ctrl[i].shift_up   = done_go && apply_ins && ge_mask[i] && !sel_ff[i];
         cell_ctrl[i].shift_down = done_go && apply_del && ge_mask[i];
      end
   end

   // Cell row, each cell wired to its neighbors
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] lower;
      logic signed [31:0] upper;

      if (g == 0) begin : g_lo_edge
         assign lower = cell_data[g];
      end else begin : g_lo
         assign lower = cell_data[g-1];
      end

      if (g == CAPACITY - 1) begin : g_hi_edge
         assign upper = cell_data[g];
      end else begin : g_hi
         assign upper = cell_data[g+1];
      end

      ale_cell u_cell (
         .clock (clock),
         .ctrl  (cell_ctrl[g]),
         .key   (req_ff.value),
         .lower (lower),
         .upper (upper),
         .entry (cell_data[g]),
         .flags (cell_flags[g])
      );
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ale_pkg::S_IDLE: if (req_if.valid) state_in = ale_pkg::S_CMP;
         ale_pkg::S_CMP:  state_in = ale_pkg::S_SCAN;
         ale_pkg::S_SCAN: state_in = ale_pkg::S_DONE;
         ale_pkg::S_DONE: if (rsp_free) state_in = ale_pkg::S_IDLE;
         default:         state_in = ale_pkg::S_IDLE;
      endcase
   end

   assign count_in = done_go ? count_next : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ale_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_if.payload;
      end
      if (state_ff == ale_pkg::S_SCAN) begin
         sel_ff <= sel_in;
      end
      if (done_go) begin
         rsp_data_ff.status <= status_c;
         rsp_data_ff.index  <= index_c;
         rsp_data_ff.count  <= cnt_out_ext[4:0];
      end
   end

   assign req_if.ready   = (state_ff == ale_pkg::S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(CAPACITY))
      else $error("entry count above capacity");

   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ale_pkg::S_DONE) |-> $onehot0(sel_ff))
      else $error("slot select not one-hot");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (done_go && status_c == ale_pkg::ST_FULL) |-> is_full)
      else $error("full status with room left");

   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ale_pkg::S_CMP))
      else $error("accepted request did not start compare");

endmodule

`default_nettype wire

/* tb/array_list_engine_test.sv */
`timescale 1ns / 1ps

module array_list_engine_test;

   localparam int LIST_CAP     = 16;
   localparam int RAND_REQS    = 850;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;

   // func codes past clear do nothing
   localparam logic [2:0] FN_UNUSED_LO = ale_pkg::FN_CLEAR + 3'd1;
   localparam logic [2:0] FN_UNUSED_HI = 3'd7;

   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

   logic clock;
   logic reset;

   ale_stream_if #(.payload_type(ale_pkg::ale_req_type)) req_ch ();
   ale_stream_if #(.payload_type(ale_pkg::ale_rsp_type)) rsp_ch ();

   array_list_engine #(
      .CAPACITY(LIST_CAP)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   // list shadow used for prediction
   logic signed [31:0] list_vals [LIST_CAP];
   int unsigned        list_len;

   ale_pkg::ale_req_type pending_reqs [$];
   ale_pkg::ale_rsp_type list_rsp_due [$];
   ale_pkg::ale_rsp_type rsp_want;

   int send_idle_pct;
   int rsp_stall_pct;
   int error_count;
   int cycle_count;
   int reqs_sent;
   int rsps_seen;
   int status_tally [4];

   // entry count as the request stream leaves the generator
   int unsigned        gen_count;
   logic signed [31:0] value_pool [8];

   // clock and reset
   initial clock = 1'b0;
   always #5ns clock = ~clock;

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.payload   = '0;
      rsp_ch.ready     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ------------------------------------------------------------------
   // list behavior
   // ------------------------------------------------------------------
   function automatic void open_slot(int unsigned slot, logic signed [31:0] v);
      for (int unsigned i = list_len; i > slot; i--)
         list_vals[i] = list_vals[i - 1];
      list_vals[slot] = v;
      list_len++;
   endfunction

   function automatic ale_pkg::ale_rsp_type apply_list_op(ale_pkg::ale_req_type r);
      ale_pkg::ale_rsp_type rsp;
      int unsigned slot;
      int unsigned pos;
      rsp  = '0;
      slot = 0;
      pos  = 32'(r.position);
      rsp.status = ale_pkg::ST_OK;
      case (r.func)
         ale_pkg::FN_INSERT: begin
            if (pos > list_len) begin
               rsp.status = ale_pkg::ST_BADPOS;
            end else if (list_len >= LIST_CAP) begin
               rsp.status = ale_pkg::ST_FULL;
            end else begin
               open_slot(pos, r.value);
               rsp.index = r.position[3:0];
            end
         end
         ale_pkg::FN_DELETE: begin
            if (pos >= list_len) begin
               rsp.status = ale_pkg::ST_BADPOS;
            end else begin
               for (int unsigned i = pos; i + 1 < list_len; i++)
                  list_vals[i] = list_vals[i + 1];
               list_len--;
            end
         end
         ale_pkg::FN_LOCATE: begin
            rsp.status = ale_pkg::ST_NOTFOUND;
            for (int unsigned i = 0; i < list_len; i++) begin
               if (rsp.status == ale_pkg::ST_NOTFOUND && list_vals[i] == r.value) begin
                  rsp.status = ale_pkg::ST_OK;
                  rsp.index  = i[3:0];
               end
            end
         end
         ale_pkg::FN_SORTED: begin
            if (list_len >= LIST_CAP) begin
               rsp.status = ale_pkg::ST_FULL;
            end else begin
               // signed compare: stop at first entry not smaller
               while (slot < list_len && list_vals[slot] < r.value) slot++;
               open_slot(slot, r.value);
               rsp.index = slot[3:0];
            end
         end
         ale_pkg::FN_CLEAR: list_len = 0;
         default: ;
      endcase
      rsp.count = list_len[4:0];
      status_tally[rsp.status]++;
      return rsp;
   endfunction

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            list_rsp_due.push_back(apply_list_op(req_ch.payload));
            reqs_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid   <= 1'b1;
               req_ch.payload <= pending_reqs.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // response monitor
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, int got, int want);
      $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsps_seen++;
            if (list_rsp_due.size() == 0) begin
               report_mismatch("response with no request outstanding, status",
                               int'(rsp_ch.payload.status), -1);
            end else begin
               rsp_want = list_rsp_due.pop_front();
               if (rsp_ch.payload.status !== rsp_want.status)
                  report_mismatch("status", int'(rsp_ch.payload.status),
                                  int'(rsp_want.status));
               if (rsp_ch.payload.index !== rsp_want.index)
                  report_mismatch("index", int'(rsp_ch.payload.index),
                                  int'(rsp_want.index));
               if (rsp_ch.payload.count !== rsp_want.count)
                  report_mismatch("count", int'(rsp_ch.payload.count),
                                  int'(rsp_want.count));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic push_req(logic [2:0] func, logic signed [31:0] value,
                           logic [4:0] position);
      ale_pkg::ale_req_type r;
      r.func     = func;
      r.value    = value;
      r.position = position;
      pending_reqs.push_back(r);
      // track the count so positions can be kept mostly in range
      case (func)
         ale_pkg::FN_INSERT:
            if (32'(position) <= gen_count && gen_count < LIST_CAP) gen_count++;
         ale_pkg::FN_DELETE: if (32'(position) < gen_count) gen_count--;
         ale_pkg::FN_SORTED: if (gen_count < LIST_CAP) gen_count++;
         ale_pkg::FN_CLEAR:  gen_count = 0;
         default: ;
      endcase
   endtask

   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      int roll;
      roll = $urandom_range(9);
      if (roll < 6) begin
         v = value_pool[$urandom_range(7)];
      end else if (roll < 8) begin
         v = $urandom_range(8);
         v = v - 32'sd4;
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   task automatic queue_random_reqs(int n);
      int roll;
      // small pool so locates hit and sorted inserts see equal keys
      value_pool[0] = VAL_MIN;
      value_pool[1] = VAL_MAX;
      for (int k = 2; k < 8; k++) value_pool[k] = $urandom;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(99);
         if (roll < 22) begin
            push_req(ale_pkg::FN_INSERT, pick_value(), 5'($urandom_range(gen_count)));
         end else if (roll < 42) begin
            push_req(ale_pkg::FN_SORTED, pick_value(), 5'($urandom));
         end else if (roll < 64) begin
            push_req(ale_pkg::FN_DELETE, $urandom,
                     (gen_count != 0) ? 5'($urandom_range(gen_count - 1)) : 5'd0);
         end else if (roll < 85) begin
            push_req(ale_pkg::FN_LOCATE, pick_value(), 5'($urandom));
         end else if (roll < 88) begin
            push_req(ale_pkg::FN_CLEAR, $urandom, 5'($urandom));
         end else if (roll < 91) begin
            push_req(3'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO)), $urandom,
                     5'($urandom));
         end else begin
            // noise: any code, any position
            push_req(3'($urandom_range(FN_UNUSED_HI)), pick_value(), 5'($urandom));
         end
      end
   endtask

   // sampled between edges so the driver and monitor have settled
   task automatic drain_list();
      while (pending_reqs.size() != 0 || req_ch.valid || list_rsp_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int idle_plan [4][2];
      idle_plan = '{'{0, 0}, '{57, 0}, '{0, 57}, '{13, 13}};
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      gen_count     = 0;
      list_len      = 0;

      // directed: empty list errors
      push_req(ale_pkg::FN_LOCATE, 32'sd5, 5'd0);
      push_req(ale_pkg::FN_DELETE, 32'sd0, 5'd0);
      push_req(ale_pkg::FN_INSERT, 32'sd1, 5'd1);
      // sorted inserts of the extremes and around zero
      push_req(ale_pkg::FN_SORTED, VAL_MAX, 5'd0);
      push_req(ale_pkg::FN_SORTED, VAL_MIN, 5'd0);
      push_req(ale_pkg::FN_SORTED, 32'sd0, 5'd0);
      push_req(ale_pkg::FN_SORTED, -32'sd1, 5'd0);
      // fill to capacity by positional inserts
      for (int k = 4; k < LIST_CAP; k++)
         push_req(ale_pkg::FN_INSERT, $urandom, 5'($urandom_range(k)));
      // full list; bad position wins over full
      push_req(ale_pkg::FN_INSERT, 32'sd7, 5'd16);
      push_req(ale_pkg::FN_SORTED, 32'sd7, 5'd0);
      push_req(ale_pkg::FN_INSERT, 32'sd7, 5'd17);
      push_req(ale_pkg::FN_LOCATE, VAL_MIN, 5'd0);
      push_req(ale_pkg::FN_LOCATE, VAL_MAX, 5'd0);
      push_req(ale_pkg::FN_DELETE, 32'sd0, 5'd31);
      push_req(ale_pkg::FN_DELETE, 32'sd0, 5'd0);
      // insert at the tail slot
      push_req(ale_pkg::FN_INSERT, 32'sd99, 5'd15);
      for (int f = int'(FN_UNUSED_LO); f <= int'(FN_UNUSED_HI); f++)
         push_req(f[2:0], $urandom, 5'($urandom));
      push_req(ale_pkg::FN_CLEAR, 32'sd0, 5'd0);
      drain_list();

      // random traffic under each idle pattern
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p][0];
         rsp_stall_pct = idle_plan[p][1];
         queue_random_reqs(RAND_REQS / 4);
         drain_list();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (list_rsp_due.size() != 0 || rsps_seen != reqs_sent)
         report_mismatch("responses received vs requests sent", rsps_seen, reqs_sent);
      $display("covered %0d requests, %0d responses over four idle patterns",
               reqs_sent, rsps_seen);
      $display("status mix: ok %0d, bad position %0d, list full %0d, not found %0d",
               status_tally[ale_pkg::ST_OK], status_tally[ale_pkg::ST_BADPOS],
               status_tally[ale_pkg::ST_FULL], status_tally[ale_pkg::ST_NOTFOUND]);
      if (error_count == 0) begin
         $display("array_list_engine: match");
      end else begin
         $display("array_list_engine: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("array_list_engine: mismatch");
      $finish;
   end

endmodule

/* sim.f */
design/ale_pkg.sv
design/ale_stream_if.sv
design/ale_cell.sv
design/array_list_engine.sv
tb/array_list_engine_test.sv
